// ===== hw/rtl/dqb_pkg.sv =====
package dqb_pkg;

  localparam int MAX_LABEL   = 63;
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int CMD_DEPTH   = 4;
  localparam int HDR_BYTES   = 12;
  localparam int TRL_BYTES   = 5;

  localparam logic [7:0]  DOT_CHAR    = 8'h2E;
  localparam logic [15:0] HDR_FLAGS   = 16'h0100;
  localparam logic [15:0] HDR_QDCOUNT = 16'h0001;
  localparam logic [15:0] QCLASS_IN   = 16'h0001;

  typedef enum logic {
    REG_QUERY_TYPE = 1'b0,
    REG_QUERY_ID   = 1'b1
  } reg_idx_e;

  // One queue entry: the work one accepted request leaves for the back end.
  typedef struct packed {
    logic             hdr;     // emit the header first
    logic             close;   // close the buffered label
    logic [CNT_W-1:0] count;   // saturated label length
    logic             extra;   // empty final label after a trailing dot
    logic             trail;   // terminator, type and class, end of message
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HDR,
    B_LEN,
    B_DATA,
    B_EMPTY,
    B_TRL
  } back_state_e;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0:    b = id[15:8];
      4'd1:    b = id[7:0];
      4'd2:    b = HDR_FLAGS[15:8];
      4'd3:    b = HDR_FLAGS[7:0];
      4'd4:    b = HDR_QDCOUNT[15:8];
      4'd5:    b = HDR_QDCOUNT[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trl_byte(input logic [2:0] idx, input logic [15:0] qtype);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd1:    b = qtype[15:8];
      3'd2:    b = qtype[7:0];
      3'd3:    b = QCLASS_IN[15:8];
      3'd4:    b = QCLASS_IN[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/dns_query_builder_core.sv =====
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+--------------------------------------
// name     | in        | in_valid_i / in_stall_o  | name_char_i[7:0], name_last_i
// message  | out       | out_valid_o / out_stall_i| out_word_o[15:0], out_two_bytes_o,
//          |           |                          | out_last_o, out_error_o
// config   | in        | APB psel/penable/pwrite  | paddr[2:0], pwdata/prdata[31:0]
//
// The back end produces one message byte per cycle while it has work and the
// output does not stall, and pairs the bytes into words: 12 header bytes, one
// per stored label character and one length byte per label, 5 trailer bytes. A
// name character is taken in the cycle it is offered unless in_stall_o is high.
// After a dot or the last character the front holds further requests until
// the label has been read out of the store, since both share that single store.
// Reset is asynchronous, active low, and clears all control state; no clearing
// pass is needed. A stalled output holds the back end only when a word is due.
module dns_query_builder_core
  import dqb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // name character requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  name_char_i,
  input  logic        name_last_i,
  // message words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_word_o,
  output logic        out_two_bytes_o,
  output logic        out_last_o,
  output logic        out_error_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]         qtype_q, qid_q;
  reg_idx_e            reg_sel;
  logic                cfg_wr;

  logic                push, pop, fifo_empty, fifo_full, label_done;
  cmd_t                push_cmd, head_cmd;
  logic                ram_we, ram_re;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  // Registers sit at byte 0 and 4; decode on the word bit alone.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_QUERY_TYPE: prdata = {16'h0000, qtype_q};
      REG_QUERY_ID:   prdata = {16'h0000, qid_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qtype_q <= 16'h0001;
      qid_q   <= 16'h0000;
    end else if (cfg_wr) begin
      if (reg_sel == REG_QUERY_TYPE) begin
        qtype_q <= pwdata[15:0];
      end else begin
        qid_q <= pwdata[15:0];
      end
    end
  end

  // Front: take characters, fill the label store, queue header/label/trailer work.
  dqb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .name_char_i  (name_char_i),
    .name_last_i  (name_last_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .label_done_i (label_done),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  // Short queue that lets front and back stall independently.
  dqb_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (fifo_empty),
    .full_o     (fifo_full)
  );

  // Label store: written by the front, read by the back.
  dqb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_label_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back: byte sequencer and word packer with the output register.
  dqb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .query_type_i    (qtype_q),
    .query_id_i      (qid_q),
    .head_i          (head_cmd),
    .empty_i         (fifo_empty),
    .pop_o           (pop),
    .label_done_o    (label_done),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_o      (out_word_o),
    .out_two_bytes_o (out_two_bytes_o),
    .out_last_o      (out_last_o),
    .out_error_o     (out_error_o)
  );

endmodule

// ===== hw/rtl/dqb_ram.sv =====
module dqb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dqb_cmd_fifo.sv =====
module dqb_cmd_fifo
  import dqb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PW = $clog2(CMD_DEPTH);

  cmd_t            slot_q [CMD_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]     fill_q, fill_d;
  logic            do_push, do_pop;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == (PW+1)'(CMD_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + PW'(1) : wptr_q;
    rptr_d = do_pop  ? rptr_q + PW'(1) : rptr_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/dqb_front.sv =====
module dqb_front
  import dqb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          name_char_i,
  input  logic                name_last_i,
  input  logic                fifo_full_i,
  output logic                push_o,
  output cmd_t                push_cmd_o,
  input  logic                label_done_i,
  output logic                ram_we_o,
  output logic [STORE_AW-1:0] ram_waddr_o,
  output logic [7:0]          ram_wdata_o
);

  logic [CNT_W-1:0] count_q, count_d, count_inc;
  logic             hdr_sent_q, hdr_sent_d;
  logic             busy_q, busy_d;
  logic             accept, is_dot;

  // Hold off while the back end still reads the label store or the queue is full.
  assign in_stall_o = busy_q || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_dot     = (name_char_i == DOT_CHAR);

  assign ram_we_o    = accept && !is_dot && (count_q < CNT_W'(MAX_LABEL));
  assign ram_waddr_o = count_q[STORE_AW-1:0];
  assign ram_wdata_o = name_char_i;

  assign count_inc = (count_q <= CNT_W'(MAX_LABEL)) ? count_q + CNT_W'(1) : count_q;

  always_comb begin
    push_cmd_o       = '0;
    push_cmd_o.hdr   = !hdr_sent_q;
    count_d          = count_q;
    hdr_sent_d       = hdr_sent_q;
    busy_d           = busy_q;

    if (is_dot) begin
      push_cmd_o.close = 1'b1;
      push_cmd_o.count = count_q;
      push_cmd_o.extra = name_last_i;
    end else if (name_last_i) begin
      push_cmd_o.close = 1'b1;
      push_cmd_o.count = count_inc;
    end
    push_cmd_o.trail = name_last_i;

    push_o = accept && (push_cmd_o.hdr || push_cmd_o.close || push_cmd_o.trail);

    if (label_done_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      if (is_dot || name_last_i) begin
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
      hdr_sent_d = !name_last_i;
      if (push_cmd_o.close) begin
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      hdr_sent_q <= 1'b0;
      busy_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      hdr_sent_q <= hdr_sent_d;
      busy_q     <= busy_d;
    end
  end

endmodule

// ===== hw/rtl/dqb_back.sv =====
module dqb_back
  import dqb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         query_type_i,
  input  logic [15:0]         query_id_i,
  input  cmd_t                head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                label_done_o,
  output logic                ram_re_o,
  output logic [STORE_AW-1:0] ram_raddr_o,
  input  logic [7:0]          ram_rdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         out_word_o,
  output logic                out_two_bytes_o,
  output logic                out_last_o,
  output logic                out_error_o
);

  back_state_e         state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [STORE_AW-1:0] idx_q, idx_d;
  logic [7:0]          pend_b_q, pend_b_d;
  logic                pend_v_q, pend_v_d;
  logic                err_q, err_d;
  logic                ov_q, ov_d;
  logic [15:0]         word_q, word_d;
  logic                two_q, two_d;
  logic                last_q, last_d;
  logic                eword_q, eword_d;

  logic                byte_v, final_b, byte_ok, adv;
  logic [7:0]          byte_val;
  logic [STORE_AW-1:0] clip_len;
  logic                bad_len;

  assign clip_len = (cmd_q.count > CNT_W'(MAX_LABEL)) ? STORE_AW'(MAX_LABEL)
                                                      : cmd_q.count[STORE_AW-1:0];
  assign bad_len  = (cmd_q.count == '0) || (cmd_q.count > CNT_W'(MAX_LABEL));

  assign out_valid_o     = ov_q;
  assign out_word_o      = word_q;
  assign out_two_bytes_o = two_q;
  assign out_last_o      = last_q;
  assign out_error_o     = eword_q;

  always_comb begin
    cmd_d        = cmd_q;
    state_d      = state_q;
    idx_d        = idx_q;
    pend_b_d     = pend_b_q;
    pend_v_d     = pend_v_q;
    err_d        = err_q;
    word_d       = word_q;
    two_d        = two_q;
    last_d       = last_q;
    eword_d      = eword_q;
    ov_d         = ov_q && out_stall_i;
    pop_o        = 1'b0;
    label_done_o = 1'b0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = idx_q + STORE_AW'(1);
    byte_v       = 1'b0;
    final_b      = 1'b0;
    byte_val     = 8'h00;

    unique case (state_q)
      B_HDR: begin
        byte_v   = 1'b1;
        byte_val = hdr_byte(idx_q[3:0], query_id_i);
      end
      B_LEN: begin
        byte_v   = 1'b1;
        byte_val = {2'b00, clip_len};
      end
      B_DATA: begin
        byte_v   = 1'b1;
        byte_val = ram_rdata_i;
      end
      B_EMPTY: begin
        byte_v   = 1'b1;
        byte_val = 8'h00;
      end
      B_TRL: begin
        byte_v   = 1'b1;
        byte_val = trl_byte(idx_q[2:0], query_type_i);
        final_b  = (idx_q == STORE_AW'(TRL_BYTES - 1));
      end
      default: begin
        byte_v = 1'b0;
      end
    endcase

    // A byte that completes a word, or ends the message, needs the output slot.
    byte_ok = !(pend_v_q || final_b) || !ov_q || !out_stall_i;
    adv     = byte_v && byte_ok;

    if (adv) begin
      if (pend_v_q || final_b) begin
        ov_d    = 1'b1;
        word_d  = pend_v_q ? {pend_b_q, byte_val} : {byte_val, 8'h00};
        two_d   = pend_v_q;
        last_d  = final_b;
        eword_d = err_q;
        pend_v_d = 1'b0;
      end else begin
        pend_b_d = byte_val;
        pend_v_d = 1'b1;
      end
    end

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          idx_d = '0;
          if (head_i.hdr) begin
            state_d  = B_HDR;
            err_d    = 1'b0;
            pend_v_d = 1'b0;
          end else begin
            state_d = B_LEN;
            err_d   = err_q || (head_i.count == '0) || (head_i.count > CNT_W'(MAX_LABEL));
          end
        end
      end
      B_HDR: begin
        if (adv) begin
          idx_d = idx_q + STORE_AW'(1);
          if (idx_q == STORE_AW'(HDR_BYTES - 1)) begin
            idx_d = '0;
            if (cmd_q.close) begin
              state_d = B_LEN;
              err_d   = err_q || bad_len;
            end else begin
              state_d = B_IDLE;
            end
          end
        end
      end
      B_LEN: begin
        if (adv) begin
          idx_d = '0;
          if (clip_len != '0) begin
            state_d     = B_DATA;
            ram_re_o    = 1'b1;
            ram_raddr_o = '0;
          end else begin
            label_done_o = 1'b1;
            if (cmd_q.extra) begin
              state_d = B_EMPTY;
              err_d   = 1'b1;
            end else if (cmd_q.trail) begin
              state_d = B_TRL;
            end else begin
              state_d = B_IDLE;
            end
          end
        end
      end
      B_DATA: begin
        if (adv) begin
          if (idx_q == clip_len - STORE_AW'(1)) begin
            label_done_o = 1'b1;
            idx_d        = '0;
            if (cmd_q.extra) begin
              state_d = B_EMPTY;
              err_d   = 1'b1;
            end else if (cmd_q.trail) begin
              state_d = B_TRL;
            end else begin
              state_d = B_IDLE;
            end
          end else begin
            ram_re_o = 1'b1;
            idx_d    = idx_q + STORE_AW'(1);
          end
        end
      end
      B_EMPTY: begin
        if (adv) begin
          state_d = B_TRL;
          idx_d   = '0;
        end
      end
      B_TRL: begin
        if (adv) begin
          idx_d = idx_q + STORE_AW'(1);
          if (final_b) begin
            state_d = B_IDLE;
            idx_d   = '0;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      pend_b_q <= 8'h00;
      err_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      pend_b_q <= pend_b_d;
      err_q    <= err_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    word_q  <= word_d;
    two_q   <= two_d;
    last_q  <= last_d;
    eword_q <= eword_d;
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import dqb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Message layout constants, written out here so that the package is not
  // trusted for the values that it is meant to produce.
  localparam logic [7:0]  PERIOD     = 8'h2E;
  localparam int unsigned LABEL_MAX  = 63;
  localparam logic [15:0] FLAGS_RD   = 16'h0100;
  localparam logic [15:0] ONE_QUERY  = 16'h0001;
  localparam logic [15:0] CLASS_IN   = 16'h0001;

  // Cycles to let pass after the last word before touching the registers,
  // and at the very end: a full label read-out plus the trailer, with margin.
  localparam int SETTLE      = 100;
  localparam int DRAIN_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [15:0] word;
    logic        two;
    logic        fin;
    logic        err;
  } msg_word_t;

  // DUT connections; every input starts at a known value.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  name_char_i = 8'h00;
  logic        name_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] out_word_o;
  logic        out_two_bytes_o;
  logic        out_last_o;
  logic        out_error_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = 3'd0;
  logic [31:0] pwdata      = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  dns_query_builder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .name_char_i     (name_char_i),
    .name_last_i     (name_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_o      (out_word_o),
    .out_two_bytes_o (out_two_bytes_o),
    .out_last_o      (out_last_o),
    .out_error_o     (out_error_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Fail the run if it hangs anywhere.
  initial begin
    #400000;
    $display("FAIL dns_query_builder_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Encoder prediction: its own copy of the registers and the message state.
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_type = 16'h0001;
  logic [15:0] cfg_id   = 16'h0000;

  logic [7:0]  lbl_mem [64];
  int unsigned lbl_len    = 0;
  bit          hdr_done   = 1'b0;
  bit          odd_valid  = 1'b0;
  logic [7:0]  odd_byte   = 8'h00;
  bit          err_flag   = 1'b0;

  msg_word_t   word_q[$];      // words still owed by the block, oldest first
  logic [7:0]  name_buf[$];    // host name being assembled for the next send

  int n_errors = 0;
  int n_sent   = 0;

  // Idling knobs, changed by the tests.
  int tx_max_gap   = 0;
  int rx_max_stall = 0;
  int hold_req     = 0;

  // Pair bytes into big-endian words; an odd byte waits for its partner.
  function automatic void put_byte(logic [7:0] b);
    if (odd_valid) begin
      word_q.push_back(msg_word_t'{{odd_byte, b}, 1'b1, 1'b0, err_flag});
      odd_valid = 1'b0;
      odd_byte  = 8'h00;
    end else begin
      odd_byte  = b;
      odd_valid = 1'b1;
    end
  endfunction

  // Write length byte and buffered characters; empty or overlong flags error.
  function automatic void close_label();
    int unsigned n;
    int unsigned i;
    n = lbl_len;
    if (n == 0 || n > LABEL_MAX) err_flag = 1'b1;
    if (n > LABEL_MAX) n = LABEL_MAX;
    put_byte(8'(n));
    for (i = 0; i < n; i++) put_byte(lbl_mem[i]);
    lbl_len = 0;
  endfunction

  // Work out the words one accepted character request produces.
  function automatic void encode_char(logic [7:0] ch, logic is_last);
    if (!hdr_done) begin
      err_flag  = 1'b0;
      odd_valid = 1'b0;
      odd_byte  = 8'h00;
      put_byte(cfg_id[15:8]);
      put_byte(cfg_id[7:0]);
      put_byte(FLAGS_RD[15:8]);
      put_byte(FLAGS_RD[7:0]);
      put_byte(ONE_QUERY[15:8]);
      put_byte(ONE_QUERY[7:0]);
      repeat (6) put_byte(8'h00);
      hdr_done = 1'b1;
    end

    if (ch == PERIOD) begin
      close_label();
    end else begin
      // keep only the first LABEL_MAX characters, count one past to flag it
      if (lbl_len < LABEL_MAX) lbl_mem[lbl_len] = ch;
      if (lbl_len <= LABEL_MAX) lbl_len++;
      if (lbl_len > LABEL_MAX) err_flag = 1'b1;
    end

    if (is_last) begin
      close_label();
      put_byte(8'h00);
      put_byte(cfg_type[15:8]);
      put_byte(cfg_type[7:0]);
      put_byte(CLASS_IN[15:8]);
      put_byte(CLASS_IN[7:0]);
      if (odd_valid) begin
        word_q.push_back(msg_word_t'{{odd_byte, 8'h00}, 1'b0, 1'b0, err_flag});
        odd_valid = 1'b0;
        odd_byte  = 8'h00;
      end
      word_q[word_q.size()-1].fin = 1'b1;
      hdr_done = 1'b0;
      err_flag = 1'b0;
      lbl_len  = 0;
    end
  endfunction

  function automatic void check_field(string field, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Word sink: check every accepted word, then draw the stall before the next.
  // A long hold-off requested by a test is counted down here.
  // ---------------------------------------------------------------------------
  initial begin : word_sink
    int        stall_left;
    int        hold_left;
    msg_word_t exp_w;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (word_q.size() == 0) begin
          $display("%0t ns: unexpected word %h, nothing outstanding", $time, out_word_o);
          n_errors++;
        end else begin
          exp_w = word_q.pop_front();
          check_field("out_word", exp_w.word, out_word_o);
          check_field("out_two_bytes", 16'(exp_w.two), 16'(out_two_bytes_o));
          check_field("out_last", 16'(exp_w.fin), 16'(out_last_o));
          check_field("out_error", 16'(exp_w.err), 16'(out_error_o));
        end
        stall_left = $urandom_range(rx_max_stall, 0);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one character; valid stays high after acceptance until the caller
  // either replaces the payload or drops it in the same step.
  task automatic send_char(input logic [7:0] ch, input logic is_last);
    int gap;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    name_char_i <= ch;
    name_last_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    encode_char(ch, is_last);
    n_sent++;
  endtask

  // Send the assembled name; mark the final request only when it ends a message.
  task automatic send_name(input bit ends);
    int i;
    for (i = 0; i < name_buf.size(); i++)
      send_char(name_buf[i], ends && (i == name_buf.size() - 1));
    name_buf.delete();
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  // Append a label of random characters; a dot is swapped for a hyphen.
  task automatic add_label(input int len);
    logic [7:0] c;
    repeat (len) begin
      c = 8'($urandom_range(255, 0));
      if (c == PERIOD) c = 8'h2D;
      name_buf.push_back(c);
    end
  endtask

  // Drop valid and wait until every owed word has come back.
  task automatic wait_drained();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (word_q.size() != 0 && waited < DRAIN_LIMIT);
    if (word_q.size() != 0) begin
      $display("%0t ns: %0d expected words never arrived", $time, word_q.size());
      n_errors++;
      word_q.delete();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic reg_read_check(input reg_idx_e idx, input logic [15:0] exp_v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field(idx.name(), exp_v, prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_QUERY_TYPE) cfg_type = val;
    else cfg_id = val;
    reg_read_check(idx, val);
  endtask

  // Reprogram only once the block is quiet: drained, then given time to settle.
  task automatic set_config(input logic [15:0] qtype, input logic [15:0] qid);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    reg_write(REG_QUERY_TYPE, qtype);
    reg_write(REG_QUERY_ID, qid);
  endtask

  function automatic logic [15:0] pick_value();
    int sel;
    sel = $urandom_range(3, 0);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF, 0));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers come up as type 1, id 0; encode one name with them.
  task automatic test_reset_values();
    reg_read_check(REG_QUERY_TYPE, 16'h0001);
    reg_read_check(REG_QUERY_ID, 16'h0000);
    tx_max_gap   = 0;
    rx_max_stall = 0;
    add_text("ab");
    send_name(1'b1);
  endtask

  // Short names covering odd and even lengths, extreme characters, empty
  // labels in every position, and the register extremes.
  task automatic test_directed();
    tx_max_gap   = 3;
    rx_max_stall = 3;
    set_config(16'hFFFF, 16'hFFFF);
    add_text("a");                      // single character, odd byte count
    send_name(1'b1);
    name_buf.push_back(8'h00);          // zero and all-ones are plain characters
    name_buf.push_back(8'hFF);
    name_buf.push_back(PERIOD);
    name_buf.push_back(8'h7F);
    send_name(1'b1);
    set_config(16'h0000, 16'h0000);
    add_text("ab.cd");
    send_name(1'b1);
    add_text("a..b");                   // empty label between two dots
    send_name(1'b1);
    add_text(".a");                     // empty leading label
    send_name(1'b1);
    add_text("ab.");                    // trailing dot leaves an empty final label
    send_name(1'b1);
    add_text(".");                      // dot alone: two empty labels
    send_name(1'b1);
    set_config(16'h001C, 16'hBEEF);
  endtask

  // Hold the sink off for a long stretch while a name with an overlong label,
  // a dot and a short label is pushed with no gaps, so the block fills and
  // stalls.
  task automatic test_backpressure();
    tx_max_gap   = 0;
    rx_max_stall = 2;
    hold_req     = HOLD_CYCLES;
    add_label($urandom_range(LABEL_MAX + 3, LABEL_MAX + 1));
    name_buf.push_back(PERIOD);
    add_label($urandom_range(4, 1));
    send_name(1'b1);
    wait_drained();
  endtask

  // Pause mid-message until every owed word is out, then finish the name.
  task automatic test_pause();
    tx_max_gap   = 4;
    rx_max_stall = 4;
    add_label($urandom_range(5, 1));
    name_buf.push_back(PERIOD);
    add_label($urandom_range(5, 1));
    send_name(1'b0);
    wait_drained();
    name_buf.push_back(PERIOD);
    add_label($urandom_range(5, 1));
    send_name(1'b1);
  endtask

  // Random names: mostly well-formed, with occasional empty, full-length and
  // overlong labels and trailing dots; idling and registers vary as we go.
  task automatic test_random();
    int start;
    int msgs;
    int n_lbl;
    int k;
    int pick;
    int len;
    start = n_sent;
    msgs  = 0;
    while (n_sent - start < 20) begin
      if (msgs % 4 == 3) set_config(pick_value(), pick_value());
      case ($urandom_range(3, 0))
        0: begin tx_max_gap = 0;  rx_max_stall = 0;  end
        1: begin tx_max_gap = 10; rx_max_stall = 10; end
        2: begin tx_max_gap = 0;  rx_max_stall = 10; end
        default: begin tx_max_gap = 10; rx_max_stall = 0; end
      endcase
      n_lbl = $urandom_range(3, 1);
      for (k = 0; k < n_lbl; k++) begin
        pick = $urandom_range(31, 0);
        if (pick == 0) len = 0;
        else if (pick == 1) len = $urandom_range(LABEL_MAX + 3, LABEL_MAX - 2);
        else len = $urandom_range(6, 1);
        if (k > 0) name_buf.push_back(PERIOD);
        add_label(len);
      end
      if ($urandom_range(9, 0) == 0) name_buf.push_back(PERIOD);
      if (name_buf.size() == 0) add_label(1);
      send_name(1'b1);
      msgs++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed();
    test_backpressure();
    test_pause();
    test_random();
    set_config(16'hFFFF, 16'h0000);
    test_pause();

    // drain, then give stray words a chance to show up
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS dns_query_builder_core");
    end else begin
      $display("FAIL dns_query_builder_core");
    end
    $finish;
  end

endmodule
